FILE: src/edit_distance_similarity_assert.svh
// Assertion macros for the edit distance block.
`ifndef EDIT_DISTANCE_SIMILARITY_ASSERT_SVH
`define EDIT_DISTANCE_SIMILARITY_ASSERT_SVH
`ifndef SYNTHESIS
`define EDS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define EDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define EDS_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define EDS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: src/eds_pkg.sv
package eds_pkg;
    localparam int MAX_LEN = 32;
    localparam int LW = 6;
    localparam int QD = 2;

    typedef enum logic [1:0] {
        REQ_FIRST = 2'd0,
        REQ_SECOND = 2'd1,
        REQ_FINISH = 2'd2,
        REQ_NONE = 2'd3
    } t_req;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] char_code;
    } t_in;

    typedef struct packed {
        logic [6:0] similarity_pct;
        logic [5:0] edit_distance;
        logic       length_overflow;
    } t_out;

    // front-to-back command
    typedef enum logic [1:0] {
        CMD_STORE = 2'd0,
        CMD_ROW = 2'd1,
        CMD_FIN = 2'd2,
        CMD_OVF = 2'd3
    } t_cmd_op;

    typedef struct packed {
        t_cmd_op    op;
        logic [7:0] ch;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROW,
        ST_DIV,
        ST_OUT,
        ST_CLR
    } t_state;
endpackage

FILE: src/eds_ram.sv
module eds_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: src/eds_front.sv
module eds_front import eds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_cmd_valid,
    input  logic i_cmd_ready,
    output t_cmd o_cmd,
    input  logic i_done
);
    // Track lengths to classify; queue commands to the back part.
    logic [LW-1:0] r_len_a, r_len_b, n_len_a, n_len_b;
    logic          r_fin_busy, n_fin_busy;
    t_cmd          r_q [QD];
    logic [1:0]    r_cnt;
    logic          r_rd;
    logic          acc, push, pop;
    t_cmd          cmd;

    assign o_ready = (r_cnt != 2'(QD)) && !r_fin_busy;
    assign acc = i_valid && o_ready;
    assign pop = o_cmd_valid && i_cmd_ready;
    assign o_cmd_valid = r_cnt != 2'd0;
    assign o_cmd = r_q[r_rd];

    always_comb begin
        n_len_a = r_len_a;
        n_len_b = r_len_b;
        n_fin_busy = r_fin_busy;
        push = 1'b0;
        cmd.op = CMD_STORE;
        cmd.ch = i_data.char_code;
        if (acc) begin
            case (t_req'(i_data.req_type))
                REQ_FIRST: begin
                    if (r_len_b == '0) begin
                        push = 1'b1;
                        if (r_len_a == LW'(MAX_LEN)) begin
                            cmd.op = CMD_OVF;
                        end else begin
                            n_len_a = r_len_a + 1'b1;
                        end
                    end
                end
                REQ_SECOND: begin
                    push = 1'b1;
                    if (r_len_b == LW'(MAX_LEN)) begin
                        cmd.op = CMD_OVF;
                    end else begin
                        cmd.op = CMD_ROW;
                        n_len_b = r_len_b + 1'b1;
                    end
                end
                REQ_FINISH: begin
                    push = 1'b1;
                    cmd.op = CMD_FIN;
                    n_fin_busy = 1'b1;
                    n_len_a = '0;
                    n_len_b = '0;
                end
                default: ;
            endcase
        end
        if (i_done) begin
            n_fin_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a <= '0;
            r_len_b <= '0;
            r_fin_busy <= 1'b0;
            r_cnt <= '0;
            r_rd <= 1'b0;
        end else begin
            r_len_a <= n_len_a;
            r_len_b <= n_len_b;
            r_fin_busy <= n_fin_busy;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
            if (pop) begin
                r_rd <= ~r_rd;
            end
        end
        if (push) begin
            r_q[r_rd ^ (r_cnt[0] & ~pop) ^ (pop & ~r_cnt[0] ^ pop)] <= cmd;
        end
    end
endmodule

FILE: src/eds_back.sv
module eds_back import eds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cmd_valid,
    output logic o_cmd_ready,
    input  t_cmd i_cmd,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data,
    output logic o_done
);
    `include "edit_distance_similarity_assert.svh"

    t_state r_st, n_st;
    // cost row entries 1..MAX_LEN; entry 0 always equals the second-string length
    logic [LW-1:0] r_cost [MAX_LEN];
    logic [LW-1:0] r_la, r_lb, r_i;
    logic [7:0]    r_ch;
    logic [LW-1:0] r_diag, r_left;
    logic          r_ovf;
    logic [12:0]   r_num;
    logic [6:0]    r_quo;
    logic [LW-1:0] r_div_cnt;
    logic [LW-1:0] longer;
    logic [LW-1:0] edit_dist;
    logic [7:0]    a_rd;
    logic          take;
    logic [LW-1:0] up, cand, m1;
    logic [LW-2:0] col_idx;
    logic [LW-1:0] rd_addr;
    t_out          r_out;
    logic          r_ov;

    assign take = i_cmd_valid && o_cmd_ready;
    // prefetch character 0 while idle so the first cell has it
    assign rd_addr = (r_st == ST_ROW) ? r_i : '0;

    eds_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_ram (
        .i_clk  (i_clk),
        .i_we   (take && i_cmd.op == CMD_STORE),
        .i_waddr(r_la[LW-2:0]),
        .i_wdata(i_cmd.ch),
        .i_raddr(rd_addr[LW-2:0]),
        .o_rdata(a_rd)
    );

    always_comb begin
        n_st = r_st;
        case (r_st)
            ST_IDLE: begin
                if (take && i_cmd.op == CMD_ROW) n_st = ST_ROW;
                if (take && i_cmd.op == CMD_FIN) n_st = ST_DIV;
            end
            ST_ROW: if (r_i >= r_la) n_st = ST_IDLE;
            ST_DIV: if (r_div_cnt == 6'd0) n_st = ST_OUT;
            ST_OUT: if (!r_ov || i_ready) n_st = ST_CLR;
            ST_CLR: n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    assign o_cmd_ready = (r_st == ST_IDLE);
    assign o_done = (r_st == ST_CLR);
    assign o_valid = r_ov;
    assign o_data = r_out;

    assign longer = (r_la > r_lb) ? r_la : r_lb;
    assign edit_dist = (r_la == '0) ? r_lb : r_cost[r_la[LW-2:0] - 5'd1];
    // cell: cost[i] = min(up+1, left+1, diag+sub); ram data of index i-1 ready
    assign col_idx = r_i[LW-2:0] - 5'd1;
    assign up = r_cost[col_idx];
    assign m1 = (up < r_left) ? up + 1'b1 : r_left + 1'b1;
    assign cand = (a_rd == r_ch) ? r_diag : r_diag + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_la <= '0;
            r_lb <= '0;
            r_ovf <= 1'b0;
            r_ov <= 1'b0;
            for (int k = 0; k < MAX_LEN; k++) r_cost[k] <= LW'(k + 1);
        end else begin
            r_st <= n_st;
            if (r_st == ST_OUT && (!r_ov || i_ready)) begin
                r_ov <= 1'b1;
            end else if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            case (r_st)
                ST_IDLE: begin
                    if (take) begin
                        case (i_cmd.op)
                            CMD_STORE: r_la <= r_la + 1'b1;
                            CMD_OVF: r_ovf <= 1'b1;
                            CMD_ROW: begin
                                r_lb <= r_lb + 1'b1;
                                r_ch <= i_cmd.ch;
                                r_diag <= r_lb;
                                r_left <= r_lb + 1'b1;
                                r_i <= 6'd1;
                            end
                            CMD_FIN: begin
                                r_num <= 13'(edit_dist) * 13'd100;
                                r_quo <= '0;
                                r_div_cnt <= 6'd6;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ROW: begin
                    if (r_i <= r_la) begin
                        r_cost[col_idx] <= (m1 < cand) ? m1 : cand;
                        r_left <= (m1 < cand) ? m1 : cand;
                        r_diag <= up;
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_DIV: begin
                    // restoring divide, one quotient bit per cycle
                    if ((r_num >> r_div_cnt[2:0]) >= 13'(longer)) begin
                        r_num <= r_num - (13'(longer) << r_div_cnt[2:0]);
                        r_quo[r_div_cnt[2:0]] <= 1'b1;
                    end
                    r_div_cnt <= r_div_cnt - 1'b1;
                end
                ST_OUT: begin
                    if (!r_ov || i_ready) begin
                        r_out.edit_distance <= edit_dist;
                        r_out.length_overflow <= r_ovf;
                        if (longer == '0) r_out.similarity_pct <= 7'd100;
                        else if (r_quo >= 7'd100) r_out.similarity_pct <= '0;
                        else r_out.similarity_pct <= 7'd100 - r_quo;
                    end
                end
                ST_CLR: begin
                    r_la <= '0;
                    r_lb <= '0;
                    r_ovf <= 1'b0;
                    for (int k = 0; k < MAX_LEN; k++) r_cost[k] <= LW'(k + 1);
                end
                default: ;
            endcase
        end
    end

    `EDS_ASSERT_IMP(a_fin_pct, i_clk, i_rst_n, o_valid, o_data.similarity_pct <= 7'd100)
    `EDS_ASSERT_NEXT(a_clr_idle, i_clk, i_rst_n, r_st == ST_CLR, r_st == ST_IDLE)
    `EDS_ASSERT_IMP(a_row_len, i_clk, i_rst_n, r_st == ST_ROW, r_i <= r_la + 1'b1)
endmodule

FILE: src/edit_distance_similarity.sv
// Edit distance similarity between two byte strings.
// Input channel (i_valid/o_ready, i_data): one transaction per first-string
// character, second-string character or finish. Output channel (o_valid/i_ready,
// o_data): one result transaction per finish.
// A first-string character is stored in the character RAM while the engine stays
// idle. A second-string character runs the row engine over the first string: the
// single cost cell walks the row one entry a cycle. A two-entry queue between
// classifier and row engine lets input continue while the engine works; o_ready
// drops while the queue is full. A finish reaches o_valid once the queue ahead has
// drained and the output register is free; it goes through the restoring divider,
// which forms the quotient one bit at a time, and then the output stage. Input is
// blocked from the finish until the pair is cleared. A stalled receiver holds the
// result in the output register; the next pair runs on, and its finish waits in
// the output stage until the earlier result leaves. Reset (synchronous, active
// low) clears lengths, the flag, the queue and the cost row.
module edit_distance_similarity import eds_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);
    logic cmd_valid, cmd_ready, done;
    t_cmd cmd;

    eds_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .o_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready),
        .o_cmd(cmd), .i_done(done)
    );

    eds_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(cmd_valid),
        .o_cmd_ready(cmd_ready), .i_cmd(cmd), .o_valid(o_valid),
        .i_ready(i_ready), .o_data(o_data), .o_done(done)
    );
endmodule
